[design/crdf_pkg.sv]
// Shared types and constants for the config read response deframer.
package crdf_pkg;

	// Stream framing
	localparam logic [31:0] FILLER_WORD = 32'h5555_6666;
	localparam logic [3:0]  STATUS_OK   = 4'hE;
	localparam int          TAG_W       = 28;
	localparam int          POS_W       = 3;
	localparam logic [POS_W-1:0] POS_STATUS = 3'd0;
	localparam logic [POS_W-1:0] POS_LAST   = 3'd7;

	// Address space
	localparam logic [13:0] SPACE_BYTES = 14'd4096;
	localparam logic [15:0] OFF_UNALIGNED = 16'hFFFF;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_BITS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_READ_COUNT    = 2'd3;

	// Register file contents
	typedef struct packed {
		logic [1:0]  target_select;
		logic [1:0]  region_bits;
		logic [11:0] start_address;
		logic [12:0] read_count;
	} cfg_t;

	// One write of one or two bytes toward the destination buffer
	typedef struct packed {
		logic [11:0] byte_offset;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic        pair_write;
	} wr_t;

endpackage

[design/config_read_response_deframer_top.sv]
// Top level of the config read response deframer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid / in_stall    | response_word
//  output   | out_valid / out_stall  | byte_offset, first_byte, second_byte, pair_write
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One response word per cycle is taken while in_stall is low.
// The rate is set by the input register feeding the result register through one
// subtract and compare; the output register lets a new word enter while a result waits.
// arst_n clears the pipeline valids, the frame tracker and the registers to reset values.
// in_stall rises only while the input register is full and the result register is stalled.
module config_read_response_deframer_top
	import crdf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// response word stream
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           response_word,
	// byte write stream
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0]           byte_offset,
	output logic [7:0]            first_byte,
	output logic [7:0]            second_byte,
	output logic                  pair_write,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [31:0]      word_s1;
	logic             valid_s2;
	wr_t              wr_s2;
	logic [POS_W-1:0] pos_q;
	logic [TAG_W-1:0] tags_q;
	logic             fvalid_q;

	logic in_fire;
	logic en_s2;
	logic s1_fire;
	logic match;
	logic hit;
	wr_t  wr_next;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_select <= 2'd3;
			cfg_q.region_bits   <= 2'd0;
			cfg_q.start_address <= 12'd0;
			cfg_q.read_count    <= 13'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TARGET_SELECT: cfg_q.target_select <= cfg_data[1:0];
				REG_REGION_BITS:   cfg_q.region_bits   <= cfg_data[1:0];
				REG_START_ADDRESS: cfg_q.start_address <= cfg_data[11:0];
				REG_READ_COUNT:    cfg_q.read_count    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign en_s2    = !valid_s2 || !out_stall;
	assign s1_fire  = valid_s1 && en_s2;
	assign in_stall = valid_s1 && !en_s2;
	assign in_fire  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_s1 <= response_word;
		end
	end

	// Frame tracker: status word, then seven tagged data words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_STATUS;
			tags_q   <= '0;
			fvalid_q <= 1'b0;
		end else if (s1_fire) begin
			if (pos_q == POS_STATUS) begin
				if (word_s1 != FILLER_WORD) begin
					fvalid_q <= (word_s1[31:28] == STATUS_OK);
					tags_q   <= word_s1[TAG_W-1:0];
					pos_q    <= pos_q + 3'd1;
				end
			end else begin
				tags_q <= {4'd0, tags_q[TAG_W-1:4]};
				pos_q  <= pos_q + 3'd1;
			end
		end
	end

	// Data word carries the wanted tag in a valid frame
	assign match = (pos_q != POS_STATUS) && fvalid_q &&
		(tags_q[3:0] == {2'd0, cfg_q.target_select});

	crdf_write_decode u_decode (
		.word (word_s1),
		.cfg  (cfg_q),
		.hit  (hit),
		.wr   (wr_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= s1_fire && match && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && match && hit) begin
			wr_s2 <= wr_next;
		end
	end

	assign out_valid   = valid_s2;
	assign byte_offset = wr_s2.byte_offset;
	assign first_byte  = wr_s2.first_byte;
	assign second_byte = wr_s2.second_byte;
	assign pair_write  = wr_s2.pair_write;

	// Checks
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the result register could take a word");

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && pos_q == POS_LAST) |=> (pos_q == POS_STATUS))
		else $error("frame position did not return to status after the last data word");

	a_single_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !pair_write) |-> (second_byte == 8'd0))
		else $error("single byte write carries a second byte");

endmodule

[design/crdf_write_decode.sv]
// Address decode of one matching data word into a byte write.
module crdf_write_decode
	import crdf_pkg::*;
(
	input  logic [31:0] word,
	input  cfg_t        cfg,
	output logic        hit,
	output wr_t         wr
);

	logic [15:0] addr;
	logic [15:0] base;
	logic [15:0] off;
	logic [13:0] req_end;
	logic [12:0] count_m1;
	logic        req_ok;
	logic [7:0]  lo_byte;
	logic [7:0]  hi_byte;

	// Address is big-endian in the low half; data bytes in the high half
	assign addr    = {word[7:0], word[15:8]};
	assign lo_byte = word[23:16];
	assign hi_byte = word[31:24];

	// Offset from the request base, modulo 2^16
	assign base = {cfg.region_bits, 14'd0} + {4'd0, cfg.start_address};
	assign off  = addr - base;

	// Request sanity: nonzero count that stays inside the space
	assign req_end  = {2'd0, cfg.start_address} + {1'b0, cfg.read_count};
	assign req_ok   = (cfg.read_count != 13'd0) && (req_end <= SPACE_BYTES);
	assign count_m1 = cfg.read_count - 13'd1;

	// Pick the kind of write
	always_comb begin
		hit            = 1'b0;
		wr.byte_offset = off[11:0];
		wr.first_byte  = lo_byte;
		wr.second_byte = hi_byte;
		wr.pair_write  = 1'b1;
		priority if (!req_ok) begin
			hit = 1'b0;
		end else if (off == OFF_UNALIGNED) begin
			// odd start byte arrives one below the base
			hit            = 1'b1;
			wr.byte_offset = 12'd0;
			wr.first_byte  = hi_byte;
			wr.second_byte = 8'd0;
			wr.pair_write  = 1'b0;
		end else if (off >= {3'd0, cfg.read_count}) begin
			hit = 1'b0;
		end else if (off == {3'd0, count_m1}) begin
			// trailing single byte
			hit            = 1'b1;
			wr.second_byte = 8'd0;
			wr.pair_write  = 1'b0;
		end else begin
			hit = 1'b1;
		end
	end

endmodule
